>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the elevator controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define LEC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define LEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg
// Types, codes and search functions of the LOOK elevator controller.
// ----------------------------------------------------------------------------
package lec_pkg;

  localparam int unsigned MaxFloors = 32;
  localparam int unsigned FloorW    = 6;

  localparam logic [FloorW-1:0] TopFloorReset = FloorW'(MaxFloors);

  // Event codes.
  localparam logic [2:0] FuncRequest = 3'd0;
  localparam logic [2:0] FuncQuery   = 3'd1;
  localparam logic [2:0] FuncFloor   = 3'd2;
  localparam logic [2:0] FuncDoor    = 3'd3;
  localparam logic [2:0] FuncStop    = 3'd4;
  localparam logic [2:0] FuncOpen    = 3'd5;
  localparam logic [2:0] FuncClose   = 3'd6;

  // Status codes.
  localparam logic [2:0] StatEmergency   = 3'd0;
  localparam logic [2:0] StatDoorOpen    = 3'd1;
  localparam logic [2:0] StatDirChanged  = 3'd2;
  localparam logic [2:0] StatIdle        = 3'd3;
  localparam logic [2:0] StatStopped     = 3'd4;
  localparam logic [2:0] StatStartMoving = 3'd5;
  localparam logic [2:0] StatInMove      = 3'd6;

  // Motor commands.
  localparam logic [1:0] MoveNone  = 2'd0;
  localparam logic [1:0] MoveLift  = 2'd1;
  localparam logic [1:0] MoveLower = 2'd2;
  localparam logic [1:0] MoveStop  = 2'd3;

  // Door commands.
  localparam logic [1:0] DoorNone  = 2'd0;
  localparam logic [1:0] DoorOpen  = 2'd1;
  localparam logic [1:0] DoorClose = 2'd2;

  typedef struct packed {
    logic [2:0]        func;
    logic [FloorW-1:0] floor;
    logic              query_up;
    logic              door_is_open;
    logic              engine_stopped;
  } item_t;

  typedef struct packed {
    logic                 update_valid;
    logic [2:0]           status;
    logic                 can_take;
    logic [1:0]           move_cmd;
    logic [FloorW-1:0]    move_target;
    logic [1:0]           door_cmd;
    logic [MaxFloors-1:0] cancelled_mask;
  } result_t;

  // One-hot stop bit of a floor; floors outside 1..MaxFloors give zero.
  function automatic logic [MaxFloors-1:0] floor_bit(input logic [FloorW-1:0] fl);
    logic [MaxFloors-1:0] m;
    m = '0;
    for (int i = 0; i < MaxFloors; i++) begin
      m[i] = (fl == FloorW'(i + 1));
    end
    return m;
  endfunction

  // Lowest pending stop above the car, zero if none.
  function automatic logic [FloorW-1:0] nearest_above(input logic [MaxFloors-1:0] mask,
                                                      input logic [FloorW-1:0]    car);
    logic [FloorW-1:0] best;
    best = '0;
    for (int i = MaxFloors - 1; i >= 0; i--) begin
      if (mask[i] && (FloorW'(i + 1) > car)) begin
        best = FloorW'(i + 1);
      end
    end
    return best;
  endfunction

  // Highest pending stop below the car, zero if none.
  function automatic logic [FloorW-1:0] nearest_below(input logic [MaxFloors-1:0] mask,
                                                      input logic [FloorW-1:0]    car);
    logic [FloorW-1:0] best;
    best = '0;
    for (int i = 0; i < MaxFloors; i++) begin
      if (mask[i] && (FloorW'(i + 1) < car)) begin
        best = FloorW'(i + 1);
      end
    end
    return best;
  endfunction

endpackage

>>> rtl/lec_sched.sv
// ----------------------------------------------------------------------------
// lec_sched
// Car state and the LOOK scheduling decision for one event.
// ----------------------------------------------------------------------------
module lec_sched import lec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  input  logic [FloorW-1:0] top_floor_i,
  output result_t           result_o
);

  logic [MaxFloors-1:0] pending_q, pending_d;
  logic                 heading_up_q, heading_up_d;
  logic [FloorW-1:0]    car_floor_q, car_floor_d;
  logic                 moving_q, moving_d;
  logic                 door_q, door_d;

  logic [FloorW-1:0]    limit;
  logic                 req_ok;
  logic                 idle;
  logic [MaxFloors-1:0] fbit;
  logic [MaxFloors-1:0] pend_eff;
  logic [FloorW-1:0]    up_t, dn_t, ahead, behind, disp_t;
  logic                 disp_changed;
  logic                 do_dispatch;
  result_t              res;

  always_comb begin
    limit    = (top_floor_i < FloorW'(MaxFloors)) ? top_floor_i : FloorW'(MaxFloors);
    req_ok   = (item_i.floor != '0) && (item_i.floor <= limit);
    idle     = !moving_q && (pending_q == '0);
    fbit     = floor_bit(item_i.floor);
    pend_eff = ((item_i.func == FuncRequest) && req_ok) ? (pending_q | fbit) : pending_q;

    up_t   = nearest_above(pend_eff, car_floor_q);
    dn_t   = nearest_below(pend_eff, car_floor_q);
    ahead  = heading_up_q ? up_t : dn_t;
    behind = heading_up_q ? dn_t : up_t;

    // With nothing ahead the car turns around; if nothing lies behind either,
    // the only stop is the car's own floor.
    disp_changed = (ahead == '0);
    if (ahead != '0) begin
      disp_t = ahead;
    end else if (behind != '0) begin
      disp_t = behind;
    end else begin
      disp_t = car_floor_q;
    end
  end

  always_comb begin
    pending_d    = pending_q;
    heading_up_d = heading_up_q;
    car_floor_d  = car_floor_q;
    moving_d     = moving_q;
    door_d       = door_q;
    res          = '0;
    do_dispatch  = 1'b0;

    case (item_i.func)
      FuncRequest: begin
        if (req_ok) begin
          if (idle && (car_floor_q == item_i.floor)) begin
            res.door_cmd = DoorOpen;
          end else begin
            pending_d   = pend_eff;
            do_dispatch = !door_q;
          end
        end
      end
      FuncQuery: begin
        if (idle) begin
          res.can_take = 1'b1;
        end else if (heading_up_q != item_i.query_up) begin
          res.can_take = 1'b0;
        end else begin
          res.can_take = !((ahead != '0) &&
                           (heading_up_q ? (ahead < item_i.floor) : (ahead > item_i.floor)));
        end
      end
      FuncFloor: begin
        car_floor_d = item_i.floor;
        if (item_i.engine_stopped) begin
          moving_d     = 1'b0;
          pending_d    = pending_q & ~fbit;
          res.door_cmd = DoorOpen;
        end else begin
          moving_d         = 1'b1;
          res.update_valid = 1'b1;
          res.status       = door_q ? StatDoorOpen : StatInMove;
        end
      end
      FuncDoor: begin
        door_d = item_i.door_is_open;
        if (!item_i.door_is_open && !idle) begin
          do_dispatch = (pending_q != '0);
        end else begin
          res.update_valid = 1'b1;
          res.status       = item_i.door_is_open ? StatDoorOpen : StatIdle;
        end
      end
      FuncStop: begin
        moving_d           = 1'b0;
        pending_d          = '0;
        res.move_cmd       = MoveStop;
        res.cancelled_mask = pending_q;
        res.update_valid   = 1'b1;
        res.status         = StatEmergency;
      end
      FuncOpen: begin
        res.door_cmd = DoorOpen;
      end
      FuncClose: begin
        res.door_cmd = DoorClose;
      end
      default: begin
      end
    endcase

    if (do_dispatch) begin
      heading_up_d     = disp_changed ? !heading_up_q : heading_up_q;
      moving_d         = 1'b1;
      res.move_cmd     = (car_floor_q > disp_t) ? MoveLower : MoveLift;
      res.move_target  = disp_t;
      res.update_valid = 1'b1;
      res.status       = disp_changed ? StatDirChanged : StatStartMoving;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      heading_up_q <= 1'b1;
      car_floor_q  <= FloorW'(1);
      moving_q     <= 1'b0;
      door_q       <= 1'b0;
    end else if (step_i) begin
      pending_q    <= pending_d;
      heading_up_q <= heading_up_d;
      car_floor_q  <= car_floor_d;
      moving_q     <= moving_d;
      door_q       <= door_d;
    end
  end

endmodule

>>> rtl/look_elevator_controller.sv
// ----------------------------------------------------------------------------
// look_elevator_controller
// LOOK-scheduled elevator car controller with one result word per event.
// ----------------------------------------------------------------------------
// Each event word gives exactly one result word, in order. An accepted event
// sits in an input register while the scheduler works out the next car state
// and the result; the result lands in the result register once that is free,
// so each event passes the input register and then the result register. One
// event per cycle is sustained; the input side stalls only when the result
// register is full and the sink holds out_ready_i low. The top_floor register
// may be written at any time through the cfg channel, which is always ready,
// but should only change while no event is in flight.
module look_elevator_controller import lec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [FloorW-1:0]    cfg_top_floor_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           func_i,
  input  logic [FloorW-1:0]    floor_i,
  input  logic                 query_up_i,
  input  logic                 door_is_open_i,
  input  logic                 engine_stopped_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 update_valid_o,
  output logic [2:0]           status_o,
  output logic                 can_take_o,
  output logic [1:0]           move_cmd_o,
  output logic [FloorW-1:0]    move_target_o,
  output logic [1:0]           door_cmd_o,
  output logic [MaxFloors-1:0] cancelled_mask_o
);

  logic [FloorW-1:0] top_floor_q;
  item_t             in_q;
  logic              in_valid_q;
  result_t           out_q;
  logic              out_valid_q;
  result_t           sched_res;
  logic              in_fire;
  logic              out_load;
  logic              step;

  assign cfg_ready_o = 1'b1;
  assign out_load    = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && out_load;
  assign in_ready_o  = !in_valid_q || step;
  assign in_fire     = in_valid_i && in_ready_o;

  lec_sched u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .top_floor_i (top_floor_q),
    .result_o    (sched_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_floor_q <= TopFloorReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        top_floor_q <= cfg_top_floor_i;
      end
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.func           <= func_i;
      in_q.floor          <= floor_i;
      in_q.query_up       <= query_up_i;
      in_q.door_is_open   <= door_is_open_i;
      in_q.engine_stopped <= engine_stopped_i;
    end
    if (step) begin
      out_q <= sched_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign update_valid_o   = out_q.update_valid;
  assign status_o         = out_q.status;
  assign can_take_o       = out_q.can_take;
  assign move_cmd_o       = out_q.move_cmd;
  assign move_target_o    = out_q.move_target;
  assign door_cmd_o       = out_q.door_cmd;
  assign cancelled_mask_o = out_q.cancelled_mask;

endmodule

>>> rtl/lec_checker.sv
// ----------------------------------------------------------------------------
// lec_checker
// Port-level assertions for the elevator controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lec_checker import lec_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 update_valid_o,
  input logic [2:0]           status_o,
  input logic [1:0]           move_cmd_o,
  input logic [FloorW-1:0]    move_target_o,
  input logic [MaxFloors-1:0] cancelled_mask_o
);

  // A stalled result word holds still.
  `LEC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(move_cmd_o) && $stable(move_target_o) && $stable(cancelled_mask_o), "stalled result changed")

  `LEC_ASSERT(a_status_needs_update, clk_i, rst_ni, out_valid_o && !update_valid_o |-> status_o == StatEmergency, "status without update")

  // Only the stop button cancels stops, and it always reports an emergency.
  `LEC_ASSERT(a_cancel_is_stop, clk_i, rst_ni, out_valid_o && (cancelled_mask_o != '0) |-> move_cmd_o == MoveStop && update_valid_o && status_o == StatEmergency, "cancel outside stop")

  // A travel command always comes with a start or turn-around status.
  `LEC_ASSERT(a_travel_status, clk_i, rst_ni, out_valid_o && (move_cmd_o == MoveLift || move_cmd_o == MoveLower) |-> update_valid_o && (status_o == StatDirChanged || status_o == StatStartMoving), "travel without start status")

  // Once reset has been seen at an edge, the block is empty at the next one.
  `LEC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o && in_ready_o, "busy during reset")

endmodule

bind look_elevator_controller lec_checker u_lec_checker (.*);
